// ===== src/rfb_pkg.sv =====
// Package for the ring FIFO / four-slot buffer.
// Holds the shared constants, status codes and the memory command struct.
// No dependencies.
package rfb_pkg;

  // Default store depth and the fixed word width of the data fields.
  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;

  // Buffer modes.
  localparam logic MODE_RING = 1'b0;
  localparam logic MODE_FOUR = 1'b1;

  // Access kinds carried by a word.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 2'd1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command to the store: write and read enables.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

// ===== src/rfb_store.sv =====
// Single-port synchronous store of the buffer, with a clearing pass after reset.
// Depends on rfb_pkg for the word width and the command struct.
// Read data is registered: it appears in the cycle after the read command and holds until the next one.
module rfb_store #(
  parameter int DEPTH = rfb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rfb_pkg::mem_cmd_t         cmd,
  input  logic [AW-1:0]             addr,
  input  logic [rfb_pkg::DATA_W-1:0] wr_data,
  output logic [rfb_pkg::DATA_W-1:0] rd_data,
  output logic                      busy
);

  typedef enum logic [1:0] {
    CLR_BUSY = 2'b01,
    CLR_DONE = 2'b10
  } clr_state_t;

  logic [rfb_pkg::DATA_W-1:0] mem [DEPTH];
  logic [rfb_pkg::DATA_W-1:0] rd_data_r;
  clr_state_t                 clr_state_r, clr_state_nxt;
  logic [AW-1:0]              clr_cnt_r, clr_cnt_nxt;

  // Clearing sequencer: one entry a cycle from address zero upwards.
  always_comb begin
    clr_state_nxt = clr_state_r;
    clr_cnt_nxt   = clr_cnt_r;
    case (clr_state_r)
      CLR_BUSY: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_state_nxt = CLR_DONE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      CLR_DONE: begin
        clr_cnt_nxt = clr_cnt_r;
      end
      default: begin
        clr_state_nxt = CLR_BUSY;
        clr_cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_state_r <= CLR_BUSY;
      clr_cnt_r   <= '0;
    end else begin
      clr_state_r <= clr_state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  // The memory itself: the clearing pass takes the write port while it runs.
  always_ff @(posedge clk) begin
    if (clr_state_r == CLR_BUSY) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = (clr_state_r != CLR_DONE);

endmodule

// ===== src/ring_fifo_or_four_slot_buffer_core.sv =====
// Top level of the dual-mode buffer: ring FIFO or four-slot mechanism.
// Depends on rfb_pkg and rfb_store.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_func, in_write_data
//   out_     output     out_valid / out_stall out_read_data, out_status
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; its result is shown in the cycle after it is taken.
// The single store port does at most one read or one write per word, and read data is
// registered in the store and goes straight into the result slot.
// After reset the store is cleared, during which in_stall is high.
// A new word is taken while the result slot is empty or its word is being taken.
// Configuration writes are always accepted.
module ring_fifo_or_four_slot_buffer_core #(
  parameter int DEPTH = rfb_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [rfb_pkg::DATA_W-1:0]    in_write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfb_pkg::DATA_W-1:0]    out_read_data,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = (PW + 1 > 8) ? PW + 1 : 8;

  // Configuration registers.
  logic            mode_r;
  logic [7:0]      ring_size_r;

  // Ring pointers and four-slot control bits.
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic            latest_pair_r, latest_pair_nxt;
  logic            reading_pair_r, reading_pair_nxt;
  logic [1:0]      slot_idx_r, slot_idx_nxt;

  // Result slot.
  logic            out_valid_r, out_valid_nxt;
  rfb_pkg::status_t out_status_r, out_status_nxt;
  logic            from_mem_r, from_mem_nxt;

  // Store interface.
  rfb_pkg::mem_cmd_t           mem_cmd;
  logic [PW-1:0]               mem_addr;
  logic [rfb_pkg::DATA_W-1:0]  mem_rd_data;
  logic                        mem_busy;

  logic            accept;
  logic [LW-1:0]   size_ext, limit;
  logic [PW-1:0]   wp_adv, rp_adv;
  logic            w_pair, w_slot, r_pair, r_slot;

  // Words are held off during the clearing pass and while a result waits.
  assign in_stall  = mem_busy | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Ring size in use, clamped to the range two to DEPTH.
  assign size_ext = LW'(ring_size_r);
  always_comb begin
    if (size_ext < LW'(2)) begin
      limit = LW'(2);
    end else if (size_ext > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = size_ext;
    end
  end

  // Pointer advance with wrap at the ring size.
  assign wp_adv = (LW'(wp_r) + LW'(1) >= limit) ? '0 : wp_r + PW'(1);
  assign rp_adv = (LW'(rp_r) + LW'(1) >= limit) ? '0 : rp_r + PW'(1);

  // Four-slot selection: writer takes the other pair and the other slot in it.
  assign w_pair = ~reading_pair_r;
  assign w_slot = ~slot_idx_r[w_pair];
  assign r_pair = latest_pair_r;
  assign r_slot = slot_idx_r[r_pair];

  // Access decode and state update for one accepted word.
  always_comb begin
    wp_nxt           = wp_r;
    rp_nxt           = rp_r;
    latest_pair_nxt  = latest_pair_r;
    reading_pair_nxt = reading_pair_r;
    slot_idx_nxt     = slot_idx_r;
    mem_cmd          = '0;
    mem_addr         = '0;
    out_status_nxt   = out_status_r;
    from_mem_nxt     = from_mem_r;
    out_valid_nxt    = out_valid_r & out_stall;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = rfb_pkg::ST_DONE;
      from_mem_nxt   = 1'b0;
      if (mode_r == rfb_pkg::MODE_FOUR) begin
        if (in_func == rfb_pkg::FUNC_WRITE) begin
          mem_cmd.wr_en        = 1'b1;
          mem_addr             = PW'({w_pair, w_slot});
          slot_idx_nxt[w_pair] = w_slot;
          latest_pair_nxt      = w_pair;
        end else begin
          mem_cmd.rd_en    = 1'b1;
          mem_addr         = PW'({r_pair, r_slot});
          reading_pair_nxt = r_pair;
          from_mem_nxt     = 1'b1;
        end
      end else begin
        if (in_func == rfb_pkg::FUNC_WRITE) begin
          if (wp_adv == rp_r) begin
            out_status_nxt = rfb_pkg::ST_FULL;
          end else begin
            mem_cmd.wr_en = 1'b1;
            mem_addr      = wp_r;
            wp_nxt        = wp_adv;
          end
        end else begin
          if (rp_r == wp_r) begin
            out_status_nxt = rfb_pkg::ST_EMPTY;
          end else begin
            mem_cmd.rd_en = 1'b1;
            mem_addr      = rp_r;
            rp_nxt        = rp_adv;
            from_mem_nxt  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r           <= '0;
      rp_r           <= '0;
      latest_pair_r  <= 1'b0;
      reading_pair_r <= 1'b0;
      slot_idx_r     <= '0;
      out_valid_r    <= 1'b0;
      out_status_r   <= rfb_pkg::ST_DONE;
      from_mem_r     <= 1'b0;
    end else begin
      wp_r           <= wp_nxt;
      rp_r           <= rp_nxt;
      latest_pair_r  <= latest_pair_nxt;
      reading_pair_r <= reading_pair_nxt;
      slot_idx_r     <= slot_idx_nxt;
      out_valid_r    <= out_valid_nxt;
      out_status_r   <= out_status_nxt;
      from_mem_r     <= from_mem_nxt;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rfb_pkg::MODE_RING;
      ring_size_r <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfb_pkg::CFG_MODE:      mode_r      <= cfg_data[0];
        rfb_pkg::CFG_RING_SIZE: ring_size_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rfb_store #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .addr    (mem_addr),
    .wr_data (in_write_data),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  // Read data comes from the store only for a completed read.
  assign out_valid     = out_valid_r;
  assign out_read_data = from_mem_r ? mem_rd_data : '0;
  assign out_status    = out_status_r;

endmodule

// ===== src/rfb_checker.sv =====
// Port-level checks for the dual-mode buffer, bound to the top level.
// Depends on rfb_pkg and ring_fifo_or_four_slot_buffer_core.
module rfb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_func,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rfb_pkg::DATA_W-1:0] out_read_data,
  input logic [1:0]                 out_status
);

  // Reset always starts the clearing pass, so no word is taken just after it.
  a_reset_holds_off: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("word channel open straight after reset");

  // Every accepted word shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word gave no result");

  // A write never returns data.
  a_write_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == rfb_pkg::FUNC_WRITE) |=> (out_read_data == '0))
    else $error("write returned non-zero data");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_read_data) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind ring_fifo_or_four_slot_buffer_core rfb_checker u_rfb_checker (.*);
